>>> hdl/dccf_pkg.sv
// Shared constants for the DMX chunk change filter.
// No dependencies; imported by the channel interfaces and the core.
package dccf_pkg;

    localparam int LEVEL_W = 8;

    typedef logic [LEVEL_W-1:0] level_t;

    // First byte of every report
    localparam level_t REPORT_HDR = 8'h00;

endpackage

>>> hdl/dccf_in_if.sv
// Input channel: one DMX channel level per transaction, with frame markers.
// Depends on dccf_pkg.
interface dccf_in_if
    import dccf_pkg::*;
;
    logic   valid;
    logic   ready;
    level_t channel_value;
    logic   frame_last;
    logic   force_send;

    modport source (output valid, output channel_value, output frame_last,
                    output force_send, input ready);
    modport sink   (input valid, input channel_value, input frame_last,
                    input force_send, output ready);
endinterface

>>> hdl/dccf_out_if.sv
// Output channel: one report byte per transaction.
// Depends on dccf_pkg.
interface dccf_out_if
    import dccf_pkg::*;
;
    logic   valid;
    logic   ready;
    level_t report_byte;
    logic   report_end;

    modport source (output valid, output report_byte, output report_end, input ready);
    modport sink   (input valid, input report_byte, input report_end, output ready);
endinterface

>>> hdl/dccf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dccf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/dmx_chunk_change_filter_core.sv
// DMX chunk change filter: collects channel levels into chunks, compares each
// chunk with a shadow of what was last sent and emits a report on change.
// Depends on dccf_pkg, dccf_in_if, dccf_out_if and dccf_ram.

// Levels arrive one per transaction and are grouped into chunks of CHUNK_SIZE
// bytes; the frame's last byte or the universe's last byte closes a chunk
// early, zero-padded. Each closed chunk is compared against a shadow RAM of
// the levels last sent; if anything differs, or the frame was flagged with
// force_send on its first byte, the shadow is updated and a report is sent:
// 0x00, chunk index (mod 256), then CHUNK_SIZE levels with report_end on the
// last one. Bytes past UNIVERSE_SIZE are dropped. In order: a level that does
// not close a chunk is accepted, then compared with its shadow read; a byte past
// the universe is only accepted. A closing level then steps through each padded
// position, drains the last padding read when there is padding, and decides.
// A report sends its two header bytes, then each level as a chunk buffer read
// followed by output register load and shadow write back; the sink can stall it.
// After reset the shadow RAM is cleared one entry per cycle, and no level is
// accepted until the clear is done.
module dmx_chunk_change_filter_core
    import dccf_pkg::*;
#(
    parameter int UNIVERSE_SIZE = 512,
    parameter int CHUNK_SIZE    = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    dccf_in_if.sink   in_ch,
    dccf_out_if.source out_ch
);

    localparam int AW = $clog2(UNIVERSE_SIZE);
    localparam int PW = $clog2(UNIVERSE_SIZE + 1);
    localparam int OW = $clog2(CHUNK_SIZE);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CMP,
        ST_PAD,
        ST_PAD_LAST,
        ST_DECIDE,
        ST_HDR0,
        ST_HDR1,
        ST_RD,
        ST_WR
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] base_reg, base_next;
    logic [OW-1:0] off_reg, off_next;
    logic [OW-1:0] lastoff_reg, lastoff_next;
    logic [OW-1:0] k_reg, k_next;
    logic [7:0]    idx_reg, idx_next;
    logic          differs_reg, differs_next;
    logic          forced_reg, forced_next;
    logic          last_reg, last_next;
    logic          complete_reg, complete_next;
    logic          pad_chk_reg, pad_chk_next;
    level_t        level_reg, level_next;
    logic          out_valid_reg, out_valid_next;
    level_t        out_byte_reg, out_byte_next;
    logic          out_end_reg, out_end_next;

    logic          sh_we, sh_re;
    logic [AW-1:0] sh_waddr, sh_raddr;
    level_t        sh_wdata, sh_rdata;
    logic          buf_we, buf_re;
    logic [OW-1:0] buf_waddr, buf_raddr;
    level_t        buf_wdata, buf_rdata;

    logic [PW:0]   ent_sum;
    logic          ent_in;
    logic          out_free;
    logic          pos_in;
    logic          diff_now;
    level_t        body_byte;

    dccf_ram #(.WIDTH(LEVEL_W), .DEPTH(UNIVERSE_SIZE)) u_shadow (
        .clk   (clk),
        .we    (sh_we),
        .waddr (sh_waddr),
        .wdata (sh_wdata),
        .re    (sh_re),
        .raddr (sh_raddr),
        .rdata (sh_rdata)
    );

    dccf_ram #(.WIDTH(LEVEL_W), .DEPTH(CHUNK_SIZE)) u_chunk (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .re    (buf_re),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    // Shadow entry of chunk position k, and whether it lies inside the universe
    assign ent_sum  = {1'b0, base_reg} + (PW+1)'(k_reg);
    assign ent_in   = ent_sum < (PW+1)'(UNIVERSE_SIZE);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign pos_in   = pos_reg < PW'(UNIVERSE_SIZE);
    assign diff_now = differs_reg || (sh_rdata != level_reg);
    // Padded positions read as zero regardless of stale buffer contents
    assign body_byte = (k_reg <= lastoff_reg) ? buf_rdata : level_t'(0);

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.report_byte = out_byte_reg;
    assign out_ch.report_end  = out_end_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        base_next      = base_reg;
        off_next       = off_reg;
        lastoff_next   = lastoff_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        differs_next   = differs_reg;
        forced_next    = forced_reg;
        last_next      = last_reg;
        complete_next  = complete_reg;
        pad_chk_next   = pad_chk_reg;
        level_next     = level_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;

        sh_we     = 1'b0;
        sh_waddr  = ent_sum[AW-1:0];
        sh_wdata  = body_byte;
        sh_re     = 1'b0;
        sh_raddr  = ent_sum[AW-1:0];
        buf_we    = 1'b0;
        buf_waddr = off_reg;
        buf_wdata = in_ch.channel_value;
        buf_re    = 1'b0;
        buf_raddr = k_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                sh_we    = 1'b1;
                sh_waddr = clr_reg;
                sh_wdata = level_t'(0);
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(UNIVERSE_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (pos_reg == '0)
                    begin
                        forced_next = in_ch.force_send;
                    end
                    if (pos_in)
                    begin
                        sh_re         = 1'b1;
                        sh_raddr      = pos_reg[AW-1:0];
                        buf_we        = 1'b1;
                        level_next    = in_ch.channel_value;
                        last_next     = in_ch.frame_last;
                        complete_next = (off_reg == OW'(CHUNK_SIZE - 1)) || in_ch.frame_last
                                        || (pos_reg == PW'(UNIVERSE_SIZE - 1));
                        state_next    = ST_CMP;
                    end
                    else if (in_ch.frame_last)
                    begin
                        pos_next     = '0;
                        base_next    = '0;
                        off_next     = '0;
                        idx_next     = '0;
                        differs_next = 1'b0;
                    end
                end
            end

            ST_CMP:
            begin
                differs_next = diff_now;
                pos_next     = pos_reg + PW'(1);
                if (!complete_reg)
                begin
                    off_next   = off_reg + OW'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    lastoff_next = off_reg;
                    if (off_reg == OW'(CHUNK_SIZE - 1))
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        k_next       = off_reg + OW'(1);
                        pad_chk_next = 1'b0;
                        state_next   = ST_PAD;
                    end
                end
            end

            // Padding positions must match a zero shadow; reads are pipelined
            ST_PAD:
            begin
                if (pad_chk_reg && (sh_rdata != level_t'(0)))
                begin
                    differs_next = 1'b1;
                end
                sh_re        = ent_in;
                pad_chk_next = ent_in;
                if (k_reg == OW'(CHUNK_SIZE - 1))
                begin
                    state_next = ST_PAD_LAST;
                end
                else
                begin
                    k_next = k_reg + OW'(1);
                end
            end

            ST_PAD_LAST:
            begin
                if (pad_chk_reg && (sh_rdata != level_t'(0)))
                begin
                    differs_next = 1'b1;
                end
                state_next = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (differs_reg || forced_reg)
                begin
                    state_next = ST_HDR0;
                end
                else
                begin
                    differs_next = 1'b0;
                    state_next   = ST_IDLE;
                    if (last_reg)
                    begin
                        pos_next  = '0;
                        base_next = '0;
                        off_next  = '0;
                        idx_next  = '0;
                    end
                    else
                    begin
                        base_next = base_reg + PW'(CHUNK_SIZE);
                        off_next  = '0;
                        idx_next  = idx_reg + 8'd1;
                    end
                end
            end

            ST_HDR0:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = REPORT_HDR;
                    out_end_next   = 1'b0;
                    state_next     = ST_HDR1;
                end
            end

            ST_HDR1:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = idx_reg;
                    out_end_next   = 1'b0;
                    k_next         = '0;
                    state_next     = ST_RD;
                end
            end

            ST_RD:
            begin
                buf_re     = 1'b1;
                state_next = ST_WR;
            end

            // Send one body byte and write it back to the shadow
            ST_WR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = body_byte;
                    out_end_next   = (k_reg == OW'(CHUNK_SIZE - 1));
                    sh_we          = ent_in;
                    if (k_reg == OW'(CHUNK_SIZE - 1))
                    begin
                        differs_next = 1'b0;
                        state_next   = ST_IDLE;
                        if (last_reg)
                        begin
                            pos_next  = '0;
                            base_next = '0;
                            off_next  = '0;
                            idx_next  = '0;
                        end
                        else
                        begin
                            base_next = base_reg + PW'(CHUNK_SIZE);
                            off_next  = '0;
                            idx_next  = idx_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + OW'(1);
                        state_next = ST_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pos_reg       <= '0;
            base_reg      <= '0;
            off_reg       <= '0;
            idx_reg       <= '0;
            differs_reg   <= 1'b0;
            forced_reg    <= 1'b0;
            last_reg      <= 1'b0;
            complete_reg  <= 1'b0;
            pad_chk_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pos_reg       <= pos_next;
            base_reg      <= base_next;
            off_reg       <= off_next;
            idx_reg       <= idx_next;
            differs_reg   <= differs_next;
            forced_reg    <= forced_next;
            last_reg      <= last_next;
            complete_reg  <= complete_next;
            pad_chk_reg   <= pad_chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lastoff_reg  <= lastoff_next;
        k_reg        <= k_next;
        level_reg    <= level_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

endmodule

>>> verif/dmx_chunk_change_filter_core_tb.sv
// Self-checking testbench for dmx_chunk_change_filter_core: directed frames and random
// frames, with random source gaps and sink stalls against a shadow predictor.
// Depends on dccf_pkg, dccf_in_if, dccf_out_if and the core RTL.
module dmx_chunk_change_filter_core_tb;
    import dccf_pkg::*;

    localparam int UNIV          = 512;
    localparam int CHUNK         = 32;
    localparam int RANDOM_ITEMS  = 470;
    localparam int DRAIN_CYCLES  = 4 * CHUNK + 16;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        level_t report_byte;
        logic   report_end;
    } report_beat_t;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_SHADOW, FILL_TWEAK, FILL_ZERO} fill_t;

    // Tracks the sent shadow and the report bytes owed by the block.
    class chunk_scoreboard;
        level_t       shadow [UNIV];
        level_t       chunk [CHUNK];
        int unsigned  pos;
        bit           differs;
        bit           forced;
        report_beat_t owed [$];
        int unsigned  failures;

        function new();
            foreach (shadow[i]) shadow[i] = '0;
            foreach (chunk[i]) chunk[i] = '0;
            pos = 0;
            differs = 0;
            forced = 0;
            failures = 0;
        endfunction

        function int unsigned pending();
            return owed.size();
        endfunction

        function void note_level(level_t lvl, logic last, logic frc);
            int unsigned off;
            int unsigned base;
            report_beat_t beat;
            if (pos == 0)
                forced = frc;
            if (pos < UNIV)
            begin
                off = pos % CHUNK;
                base = pos - off;
                chunk[off] = lvl;
                if (shadow[pos] != lvl)
                    differs = 1;
                if (off == CHUNK - 1 || last || pos == UNIV - 1)
                begin
                    // zero padding still counts as a change against the shadow
                    for (int unsigned k = off + 1; k < CHUNK; k++)
                    begin
                        chunk[k] = '0;
                        if (base + k < UNIV && shadow[base + k] != '0)
                            differs = 1;
                    end
                    if (differs || forced)
                    begin
                        for (int unsigned k = 0; k < CHUNK; k++)
                            if (base + k < UNIV)
                                shadow[base + k] = chunk[k];
                        beat.report_byte = REPORT_HDR;
                        beat.report_end = 1'b0;
                        owed.push_back(beat);
                        beat.report_byte = level_t'((pos / CHUNK) & 8'hFF);
                        owed.push_back(beat);
                        for (int unsigned k = 0; k < CHUNK; k++)
                        begin
                            beat.report_byte = chunk[k];
                            beat.report_end = (k == CHUNK - 1);
                            owed.push_back(beat);
                        end
                    end
                    differs = 0;
                end
                pos = pos + 1;
            end
            if (last)
            begin
                pos = 0;
                differs = 0;
            end
        endfunction

        function void check_report(level_t got_byte, logic got_end);
            report_beat_t want;
            if (owed.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected report transaction: byte %02h end %0b",
                             got_byte, got_end);
                return;
            end
            want = owed.pop_front();
            if (want.report_byte !== got_byte || want.report_end !== got_end)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display({"report mismatch: expected byte %02h end %0b, ",
                              "got byte %02h end %0b"},
                             want.report_byte, want.report_end, got_byte, got_end);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dccf_in_if  in_ch ();
    dccf_out_if out_ch ();

    dmx_chunk_change_filter_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    chunk_scoreboard sb = new();
    int unsigned     burst_left = 0;
    bit              hold_request = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_level(level_t lvl, logic last, logic frc);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid         <= 1'b1;
        in_ch.channel_value <= lvl;
        in_ch.frame_last    <= last;
        in_ch.force_send    <= frc;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        sb.note_level(lvl, last, frc);
    endtask

    // force_send is random after the first byte; the block must ignore it there
    task automatic send_frame(int unsigned len, logic frc, fill_t fill);
        level_t lvl;
        logic   f;
        for (int unsigned i = 0; i < len; i++)
        begin
            case (fill)
                FILL_SHADOW: lvl = (i < UNIV) ? sb.shadow[i] : level_t'($urandom);
                FILL_TWEAK:  lvl = (i < UNIV && $urandom_range(0, 47) != 0) ? sb.shadow[i]
                                                                           : level_t'($urandom);
                FILL_ZERO:   lvl = ($urandom_range(0, 15) == 0) ? level_t'($urandom) : '0;
                default:     lvl = level_t'($urandom);
            endcase
            f = (i == 0) ? frc : 1'($urandom_range(0, 1));
            send_level(lvl, i == len - 1, f);
        end
    endtask

    // Sink: checks accepted bytes and drives ready in phases of varying stall rate
    initial
    begin : report_sink
        int unsigned hold_left;
        int unsigned phase_left;
        int unsigned stall_pct;
        hold_left = 0;
        phase_left = 0;
        stall_pct = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                sb.check_report(out_ch.report_byte, out_ch.report_end);
            if (hold_request && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 0;
            end
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(16, 200);
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            end
            phase_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned sent;
        int unsigned frames;
        int unsigned len;
        logic        frc;
        fill_t       fill;

        in_ch.valid         <= 1'b0;
        in_ch.channel_value <= '0;
        in_ch.frame_last    <= 1'b0;
        in_ch.force_send    <= 1'b0;
        rst_n               <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // unchanged chunk after reset: no report
        send_level(8'h00, 1'b1, 1'b0);
        // forced frame of zeros
        send_level(8'h00, 1'b1, 1'b1);
        send_level(8'hFF, 1'b1, 1'b0);
        send_level(8'hFF, 1'b1, 1'b1);
        send_level(8'hFF, 1'b0, 1'b0);
        send_level(8'h5A, 1'b1, 1'b0);
        // byte 1 now stale in the shadow, padding alone must trigger a report
        send_level(8'hFF, 1'b1, 1'b0);
        // force on a non-first byte is ignored: no report
        send_level(8'hFF, 1'b0, 1'b0);
        send_level(8'h00, 1'b1, 1'b1);
        send_level(8'h80, 1'b0, 1'b0);
        send_level(8'h01, 1'b1, 1'b1);

        sent = 0;
        frames = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: len = $urandom_range(1, 40);
                5, 6:          len = CHUNK * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
                7:             len = $urandom_range(41, 120);
                8:             len = $urandom_range(1, 3);
                default:       len = $urandom_range(100, 200);
            endcase
            frc = ($urandom_range(0, 4) == 0);
            fill = fill_t'($urandom_range(0, 3));
            if (frames == 2)
            begin
                // long sink hold-off while a forced frame backs up the input
                hold_request = 1;
                frc = 1'b1;
                len = 4 * CHUNK;
            end
            if (len > RANDOM_ITEMS - sent)
                len = RANDOM_ITEMS - sent;
            send_frame(len, frc, fill);
            sent += len;
            frames++;
        end
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
